[hw/rtl/base64_stream_decoder_top_defines.svh]
// Assertion macros for the base64 stream decoder checker.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef BASE64_STREAM_DECODER_TOP_DEFINES_SVH
`define BASE64_STREAM_DECODER_TOP_DEFINES_SVH

// Check a property while out of reset.
`define B64SD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define B64SD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/b64sd_pkg.sv]
// Shared types, constants and the character table of the base64 stream decoder.
// Used by every module of the decoder; depends on nothing.
package b64sd_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

  // One run of decoded bytes caused by a single character.
  typedef struct packed {
    logic [2:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      byte_cnt;  // 1 to 3
    logic            eos;       // the character closed the string
  } run_t;

  // Map a character to its 6-bit value; unknown bytes and '=' give 0.
  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [5:0] v;
    v = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B || c == 8'h2D || c == 8'h2E) begin
      v = 6'd62;
    end else if (c == 8'h2F || c == 8'h5F || c == 8'h2C) begin
      v = 6'd63;
    end
    return v;
  endfunction

endpackage

[hw/rtl/b64sd_front.sv]
// Front end: accepts characters, tracks the group and builds byte runs.
// Depends on b64sd_pkg.
module b64sd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        char_code,
  input  logic              is_last,
  output logic              push,
  output b64sd_pkg::run_t   push_run
);

  logic [17:0] group_bits_r, group_bits_nxt;
  logic [1:0]  group_pos_r, group_pos_nxt;
  logic        prev_pad_r, prev_pad_nxt;

  logic [5:0]  v;
  logic        is_pad;
  logic [23:0] word;
  logic [5:0]  b_val, d_val;

  assign v      = b64sd_pkg::sextet_of(char_code);
  assign is_pad = (char_code == b64sd_pkg::PAD_CHAR);
  assign word   = {group_bits_r, v};
  assign b_val  = group_bits_r[11:6];
  assign d_val  = group_bits_r[5:0];

  always_comb begin
    push_run.bytes    = '0;
    push_run.byte_cnt = 2'd1;
    push_run.eos      = is_last;
    push              = 1'b0;
    if (group_pos_r == 2'd3) begin
      push              = accept;
      push_run.bytes[0] = word[23:16];
      push_run.bytes[1] = word[15:8];
      push_run.bytes[2] = word[7:0];
      if (is_last && is_pad) begin
        push_run.byte_cnt = prev_pad_r ? 2'd1 : 2'd2;
      end else begin
        push_run.byte_cnt = 2'd3;
      end
    end else if (is_last) begin
      push = accept;
      unique case (group_pos_r)
        2'd0: push_run.bytes[0] = {v, 2'b00};
        2'd1: push_run.bytes[0] = {d_val, v[5:4]};
        default: begin
          push_run.bytes[0] = {b_val, d_val[5:4]};
          push_run.bytes[1] = {d_val[3:0], v[5:2]};
          push_run.byte_cnt = 2'd2;
        end
      endcase
    end
  end

  always_comb begin
    group_bits_nxt = group_bits_r;
    group_pos_nxt  = group_pos_r;
    prev_pad_nxt   = prev_pad_r;
    if (accept) begin
      priority if (is_last) begin
        group_bits_nxt = '0;
        group_pos_nxt  = 2'd0;
        prev_pad_nxt   = 1'b0;
      end else if (group_pos_r == 2'd3) begin
        group_bits_nxt = '0;
        group_pos_nxt  = 2'd0;
        prev_pad_nxt   = is_pad;
      end else begin
        group_bits_nxt = {group_bits_r[11:0], v};
        group_pos_nxt  = group_pos_r + 2'd1;
        prev_pad_nxt   = is_pad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_bits_r <= '0;
      group_pos_r  <= 2'd0;
      prev_pad_r   <= 1'b0;
    end else begin
      group_bits_r <= group_bits_nxt;
      group_pos_r  <= group_pos_nxt;
      prev_pad_r   <= prev_pad_nxt;
    end
  end

endmodule

[hw/rtl/b64sd_queue.sv]
// Short run queue between the front and back ends of the decoder.
// Depends on b64sd_pkg.
module b64sd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64sd_pkg::run_t   push_run,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output b64sd_pkg::run_t   head_run
);

  b64sd_pkg::run_t slots_r [b64sd_pkg::QDEPTH];

  logic [b64sd_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [b64sd_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [b64sd_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic                          do_push, do_pop;

  assign full     = (count_r == b64sd_pkg::QCNT_W'(b64sd_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign head_run = slots_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[hw/rtl/b64sd_back.sv]
// Back end: sends queued byte runs one byte a cycle while out_stall is low.
// Depends on b64sd_pkg.
module b64sd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  b64sd_pkg::run_t   head_run,
  output logic              pop,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        out_data_byte,
  output logic              out_last_of_run,
  output logic              out_end_of_stream
);

  b64sd_pkg::run_t run_r, run_nxt;
  logic            run_valid_r, run_valid_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic            fire, at_end, run_done;

  assign at_end   = (idx_r == run_r.byte_cnt - 2'd1);
  assign fire     = run_valid_r && !out_stall;
  assign run_done = fire && at_end;
  assign pop      = (!run_valid_r || run_done) && !q_empty;

  assign out_valid         = run_valid_r;
  assign out_last_of_run   = at_end;
  assign out_end_of_stream = at_end && run_r.eos;

  always_comb begin
    unique case (idx_r)
      2'd0:    out_data_byte = run_r.bytes[0];
      2'd1:    out_data_byte = run_r.bytes[1];
      default: out_data_byte = run_r.bytes[2];
    endcase
  end

  always_comb begin
    run_nxt       = run_r;
    run_valid_nxt = run_valid_r;
    idx_nxt       = idx_r;
    priority if (pop) begin
      run_nxt       = head_run;
      run_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end else if (run_done) begin
      run_valid_nxt = 1'b0;
      idx_nxt       = 2'd0;
    end else if (fire) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      run_valid_r <= run_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule

[hw/rtl/base64_stream_decoder_top.sv]
// Streaming base64 decoder, one character per cycle in while in_stall is low, one byte
// per cycle out while out_stall is low. A run built from an accepted character goes
// into the run queue, then the back end's run register; a four-character group without
// padding gives three bytes; the input stalls only while the four-entry queue is full.
// Reset: synchronous, active low; clears the group state, queue and output.
// Depends on b64sd_pkg, b64sd_front, b64sd_queue and b64sd_back.
module base64_stream_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_last_of_run,
  output logic       out_end_of_stream
);

  b64sd_pkg::run_t push_run, head_run;
  logic            push, pop, q_full, q_empty, accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  b64sd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .char_code (in_char_code),
    .is_last   (in_is_last),
    .push      (push),
    .push_run  (push_run)
  );

  b64sd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_run (head_run)
  );

  b64sd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .head_run          (head_run),
    .pop               (pop),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_data_byte     (out_data_byte),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_stream (out_end_of_stream)
  );

endmodule

[hw/rtl/b64sd_checker.sv]
// Port-level checker for the base64 stream decoder, bound to the top level.
// Depends on base64_stream_decoder_top_defines.svh.
`include "base64_stream_decoder_top_defines.svh"

module b64sd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_char_code,
  input logic       in_is_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_data_byte,
  input logic       out_last_of_run,
  input logic       out_end_of_stream
);

  // A stalled result keeps its byte and flags.
  `B64SD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data_byte) && $stable(out_last_of_run) && $stable(out_end_of_stream), "stalled result changed")

  // Reset leaves no result pending and the input open.
  `B64SD_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid && !in_stall, "state left after reset")

  // Input back-pressure only comes from a full queue, which implies a pending result.
  `B64SD_ASSERT(a_stall_needs_out, !out_valid |-> !in_stall, "input stalled with output idle")

endmodule

bind base64_stream_decoder_top b64sd_checker u_b64sd_checker (.*);
